FILE: rtl/core/nsc_pkg.sv
// Shared types, character codes and defaults of the NMEA sentence checker.
`default_nettype none
package nsc_pkg;

	// ASCII characters that steer the sentence parser
	localparam logic [7:0] CHR_DOLLAR = 8'h24;
	localparam logic [7:0] CHR_STAR   = 8'h2A;
	localparam logic [7:0] CHR_CR     = 8'h0D;
	localparam logic [7:0] CHR_LF     = 8'h0A;

	// Character classes handed from the front to the back
	localparam logic [2:0] CLS_DOLLAR = 3'd0;
	localparam logic [2:0] CLS_LF     = 3'd1;
	localparam logic [2:0] CLS_CR     = 3'd2;
	localparam logic [2:0] CLS_STAR   = 3'd3;
	localparam logic [2:0] CLS_HEX    = 3'd4;
	localparam logic [2:0] CLS_OTHER  = 3'd5;

	// Configuration register indexes
	localparam logic REG_MAX_LEN   = 1'b0;
	localparam logic REG_TYPE_WORD = 1'b1;

	// Register reset values
	localparam logic [7:0]  MAX_LEN_RESET   = 8'd76;
	localparam logic [39:0] TYPE_WORD_RESET = 40'h474E524D43;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Header holds five characters after the dollar sign
	localparam logic [7:0] HDR_LAST_POS = 8'd5;
	localparam logic [7:0] HDR_FULL_LEN = 8'd6;

	// One classified character
	typedef struct packed {
		logic [2:0] cls;
		logic [7:0] data;
		logic [3:0] digit;
	} char_t;

	// One sentence verdict
	typedef struct packed {
		logic       checksum_ok;
		logic       length_ok;
		logic       type_match;
		logic       format_error;
		logic       forward_sentence;
		logic [7:0] computed_checksum;
		logic [7:0] received_checksum;
		logic [7:0] sentence_length;
	} verdict_t;

endpackage
`default_nettype wire

FILE: rtl/core/nsc_front.sv
// Front stage: accept received bytes, classify them and hand them to the queue.
`default_nettype none
module nsc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     rx_byte,
	output logic                push_valid,
	input  wire logic           push_ready,
	output nsc_pkg::char_t      push_char
);

	logic           valid_s1;
	nsc_pkg::char_t char_s1;
	nsc_pkg::char_t char_d;

	// Classify the incoming byte and decode a hex digit
	always_comb begin
		char_d.data  = rx_byte;
		char_d.digit = 4'd0;
		if (rx_byte == nsc_pkg::CHR_DOLLAR) begin
			char_d.cls = nsc_pkg::CLS_DOLLAR;
		end else if (rx_byte == nsc_pkg::CHR_LF) begin
			char_d.cls = nsc_pkg::CLS_LF;
		end else if (rx_byte == nsc_pkg::CHR_CR) begin
			char_d.cls = nsc_pkg::CLS_CR;
		end else if (rx_byte == nsc_pkg::CHR_STAR) begin
			char_d.cls = nsc_pkg::CLS_STAR;
		end else if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
			char_d.cls   = nsc_pkg::CLS_HEX;
			char_d.digit = rx_byte[3:0];
		end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
			(rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
			char_d.cls   = nsc_pkg::CLS_HEX;
			char_d.digit = rx_byte[3:0] + 4'd9;
		end else begin
			char_d.cls = nsc_pkg::CLS_OTHER;
		end
	end

	// Take a new item whenever the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_char  = char_s1;

endmodule
`default_nettype wire

FILE: rtl/core/nsc_queue.sv
// Short queue of classified characters between front and back.
`default_nettype none
module nsc_queue #(
	parameter int DEPTH = nsc_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire nsc_pkg::char_t push_char,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output nsc_pkg::char_t      pop_char
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	nsc_pkg::char_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_char   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_char;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/nsc_back.sv
// Back stage: run the sentence parser and register one verdict per sentence.
`default_nettype none
module nsc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pop_valid,
	output logic                pop_ready,
	input  wire nsc_pkg::char_t pop_char,
	input  wire logic [7:0]     max_len,
	input  wire logic [39:0]    type_word,
	output logic                out_valid,
	input  wire logic           out_ready,
	output nsc_pkg::verdict_t   verdict
);

	logic              in_sentence_q;
	logic              after_star_q;
	logic [7:0]        xor_q;
	logic [7:0]        count_q;
	logic [7:0]        hex_q;
	logic [1:0]        digits_q;
	logic              bad_digit_q;
	logic [39:0]       header_q;
	logic              out_valid_q;
	nsc_pkg::verdict_t verdict_q;
	nsc_pkg::verdict_t verdict_d;
	logic              ends_sentence;
	logic              take;

	// A line feed in a sentence needs room in the output register
	assign ends_sentence = in_sentence_q && (pop_char.cls == nsc_pkg::CLS_LF);
	assign pop_ready     = !ends_sentence || !out_valid_q || out_ready;
	assign take          = pop_valid && pop_ready;

	// Build the verdict from the current sentence state
	always_comb begin
		verdict_d.checksum_ok  = (hex_q == xor_q);
		verdict_d.length_ok    = (count_q <= max_len);
		verdict_d.type_match   = (count_q >= nsc_pkg::HDR_FULL_LEN) && (header_q == type_word);
		verdict_d.format_error = !after_star_q || (digits_q != 2'd2) || bad_digit_q;
		verdict_d.forward_sentence = verdict_d.checksum_ok && verdict_d.length_ok &&
			verdict_d.type_match && !verdict_d.format_error;
		verdict_d.computed_checksum = xor_q;
		verdict_d.received_checksum = hex_q;
		verdict_d.sentence_length   = count_q;
	end

	// Sentence parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			after_star_q  <= 1'b0;
			xor_q         <= 8'd0;
			count_q       <= 8'd0;
			hex_q         <= 8'd0;
			digits_q      <= 2'd0;
			bad_digit_q   <= 1'b0;
			header_q      <= 40'd0;
		end else if (take) begin
			if (pop_char.cls == nsc_pkg::CLS_DOLLAR) begin
				in_sentence_q <= 1'b1;
				after_star_q  <= 1'b0;
				xor_q         <= 8'd0;
				count_q       <= 8'd1;
				hex_q         <= 8'd0;
				digits_q      <= 2'd0;
				bad_digit_q   <= 1'b0;
				header_q      <= 40'd0;
			end else if (ends_sentence) begin
				in_sentence_q <= 1'b0;
				after_star_q  <= 1'b0;
				xor_q         <= 8'd0;
				count_q       <= 8'd0;
				hex_q         <= 8'd0;
				digits_q      <= 2'd0;
				bad_digit_q   <= 1'b0;
				header_q      <= 40'd0;
			end else if (in_sentence_q) begin
				// Shift the first five characters into the header
				if (count_q >= 8'd1 && count_q <= nsc_pkg::HDR_LAST_POS) begin
					header_q <= {header_q[31:0], pop_char.data};
				end
				if (count_q != 8'hFF) begin
					count_q <= count_q + 8'd1;
				end
				if (pop_char.cls != nsc_pkg::CLS_CR) begin
					if (!after_star_q) begin
						if (pop_char.cls == nsc_pkg::CLS_STAR) begin
							after_star_q <= 1'b1;
						end else begin
							xor_q <= xor_q ^ pop_char.data;
						end
					end else if (pop_char.cls != nsc_pkg::CLS_HEX) begin
						bad_digit_q <= 1'b1;
					end else if (digits_q < 2'd2) begin
						hex_q    <= {hex_q[3:0], pop_char.digit};
						digits_q <= digits_q + 2'd1;
					end else begin
						digits_q <= 2'd3;
					end
				end
			end
		end
	end

	// Output register: load on a sentence end, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && ends_sentence) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && ends_sentence) begin
			verdict_q <= verdict_d;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule
`default_nettype wire

FILE: rtl/core/nmea_sentence_checker_core.sv
// Top level of the NMEA sentence checker: configuration registers and stage wiring.
`default_nettype none
// Checks NMEA 0183 sentences from a byte stream, one byte per item. A dollar
// sign opens a sentence; on its line feed one verdict comes out with checksum,
// length, type and format results. One byte is accepted every clock cycle
// while in_ready is high. After its line feed is accepted, a verdict passes
// through the front register, the queue and the parser output register, in
// that order. A line feed waits in the parser only while the previous
// verdict is still held at the output. The queue of QUEUE_DEPTH entries and
// the front register absorb that wait. The input stalls only once they are
// full. Configuration writes are taken at once.
module nmea_sentence_checker_core #(
	parameter int QUEUE_DEPTH = nsc_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             checksum_ok,
	output logic             length_ok,
	output logic             type_match,
	output logic             format_error,
	output logic             forward_sentence,
	output logic [7:0]       computed_checksum,
	output logic [7:0]       received_checksum,
	output logic [7:0]       sentence_length,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [39:0] cfg_data
);

	logic              push_valid;
	logic              push_ready;
	nsc_pkg::char_t    push_char;
	logic              pop_valid;
	logic              pop_ready;
	nsc_pkg::char_t    pop_char;
	nsc_pkg::verdict_t verdict;
	logic [7:0]        max_len_q;
	logic [39:0]       type_word_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= nsc_pkg::MAX_LEN_RESET;
			type_word_q <= nsc_pkg::TYPE_WORD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nsc_pkg::REG_MAX_LEN: begin
					max_len_q <= cfg_data[7:0];
				end
				nsc_pkg::REG_TYPE_WORD: begin
					type_word_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	nsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_char  (push_char)
	);

	nsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_char  (push_char),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_char   (pop_char)
	);

	nsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_char  (pop_char),
		.max_len   (max_len_q),
		.type_word (type_word_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict)
	);

	// Spread the verdict onto the result ports
	assign checksum_ok       = verdict.checksum_ok;
	assign length_ok         = verdict.length_ok;
	assign type_match        = verdict.type_match;
	assign format_error      = verdict.format_error;
	assign forward_sentence  = verdict.forward_sentence;
	assign computed_checksum = verdict.computed_checksum;
	assign received_checksum = verdict.received_checksum;
	assign sentence_length   = verdict.sentence_length;

endmodule
`default_nettype wire
